/* src/tmcs_pkg.sv */
// Package for the timed motion command sequencer.
// Holds the queue depth, item kinds, register indexes, the queued command entry type and the divider request type.
// No dependencies.
package tmcs_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QIdxW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [1:0] KindDrive = 2'd0;
  localparam logic [1:0] KindTurn  = 2'd1;
  localparam logic [1:0] KindSet   = 2'd2;
  localparam logic [1:0] KindTick  = 2'd3;

  // Register indexes on the write port.
  localparam logic [1:0] RegDrive = 2'd0;
  localparam logic [1:0] RegTurn  = 2'd1;
  localparam logic [1:0] RegTick  = 2'd2;
  localparam logic [1:0] RegCal   = 2'd3;

  localparam logic signed [15:0] LevelMax = 16'sd32767;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [31:0]        ticks;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

/* src/tmcs_div.sv */
// Unsigned 32 by 32 bit restoring divider, one quotient bit per cycle.
// Depends on tmcs_pkg for the request struct.
module tmcs_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmcs_pkg::div_req_t   req_i,
  output logic                 done_o,
  output logic [31:0]          quot_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;

  // One shift and subtract step of the shared divider.
  always_comb begin
    trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (!trial[32]) begin
      rem_d = trial[31:0];
      quo_d = {quo_q[30:0], 1'b1};
    end else begin
      rem_d = {rem_q[30:0], quo_q[31]};
      quo_d = {quo_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;

endmodule

/* src/timed_motion_command_sequencer.sv */
// Top level of the timed motion command sequencer.
// Depends on tmcs_pkg and tmcs_div.
//
// Usage: items (kind, speed, amount, left_level, right_level) enter on a
// valid/ready channel; each gives one result item on a valid/ready output
// channel with the motor levels, completion count, reject flag, busy flag
// and queue level. Registers are written through a plain write port.
// A tick, set or rejected item goes from acceptance to the dispatch state,
// which dispatches queued commands, and then offers its result. An accepted
// drive or turn item goes through two passes of the shared 32 bit serial
// divider (level, then duration), or only the level pass when the duration
// needs no division, before it is queued and the dispatch state is entered.
// One item is worked on at a time. The result stays in the output register
// until taken, and the next item is accepted at the earliest in the cycle
// after that, so no new item is taken before the last result is. Reset
// empties the queue, stops any running command, zeroes the motors and
// loads the register defaults. Queue entries hold no reset value.
module timed_motion_command_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] amount_i,
  input  logic signed [15:0] left_level_i,
  input  logic signed [15:0] right_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_drive_o,
  output logic signed [15:0] right_drive_o,
  output logic [3:0]         completed_o,
  output logic               rejected_o,
  output logic               busy_res_o,
  output logic [3:0]         queue_level_o
);

  typedef enum logic [2:0] {
    StIdle, StLvl, StTck, StPush, StDisp, StOut
  } state_e;

  state_e state_q;
  logic [15:0] drive_ratio_q, turn_ratio_q, tick_rate_q;
  logic        calibrated_q;

  logic [1:0]         kind_q;
  logic signed [15:0] speed_q, amount_q, lvl_q;
  logic               neg_q;

  tmcs_pkg::cmd_t store_q [tmcs_pkg::QueueDepth];
  logic [tmcs_pkg::QIdxW-1:0] head_q, tail_q;
  logic [tmcs_pkg::QCntW-1:0] count_q;
  logic        running_q;
  logic [31:0] ticks_q;
  logic signed [15:0] left_q, right_q;
  logic [3:0]  done_q;
  logic        rej_q;

  tmcs_pkg::div_req_t req;
  logic        div_done;
  logic [31:0] quot;
  tmcs_pkg::cmd_t head_c;

  // Operand preparation for the divider.
  logic [15:0] ratio, sp_mag, am_mag, den;
  logic [31:0] lvl_sat;
  always_comb begin
    ratio  = (kind_q == tmcs_pkg::KindDrive) ? drive_ratio_q : turn_ratio_q;
    if (ratio == 16'd0) ratio = 16'd1;
    sp_mag = speed_q[15] ? 16'(-speed_q) : speed_q;
    am_mag = amount_q[15] ? 16'(-amount_q) : amount_q;
    den    = (sp_mag < ratio) ? sp_mag : ratio;
    lvl_sat = (quot > 32'd32767) ? 32'd32767 : quot;
  end

  tmcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign head_c = store_q[head_q];
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign left_drive_o  = left_q;
  assign right_drive_o = right_q;
  assign completed_o   = done_q;
  assign rejected_o    = rej_q;
  assign busy_res_o    = running_q;
  assign queue_level_o = 4'(count_q);

  // Divider requests are issued on entering the level and duration passes.
  always_comb begin
    req = '0;
    if (state_q == StIdle && in_valid_i &&
        (kind_i == tmcs_pkg::KindDrive || kind_i == tmcs_pkg::KindTurn) &&
        calibrated_q && count_q < tmcs_pkg::QCntW'(tmcs_pkg::QueueDepth)) begin
      req.start    = 1'b1;
      req.dividend = {1'b0, (speed_i[15] ? 16'(-speed_i) : speed_i), 15'd0};
      req.divisor  = {16'd0, (kind_i == tmcs_pkg::KindDrive ? drive_ratio_q
                                                             : turn_ratio_q)};
      if (req.divisor == 32'd0) req.divisor = 32'd1;
    end else if (state_q == StLvl && div_done) begin
      req.start    = (am_mag != 16'd0) && (den != 16'd0);
      req.dividend = 32'(am_mag) * 32'(tick_rate_q);
      req.divisor  = {16'd0, den};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_ratio_q <= 16'd256;
      turn_ratio_q  <= 16'd23040;
      tick_rate_q   <= 16'd1000;
      calibrated_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tmcs_pkg::RegDrive: drive_ratio_q <= cfg_data_i;
        tmcs_pkg::RegTurn:  turn_ratio_q  <= cfg_data_i;
        tmcs_pkg::RegTick:  tick_rate_q   <= cfg_data_i;
        tmcs_pkg::RegCal:   calibrated_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Queue memory write.
  always_ff @(posedge clk_i) begin
    if (state_q == StPush) begin
      store_q[tail_q] <= '{left: neg_q ? 16'(-lvl_q) : lvl_q, right: lvl_q,
                           ticks: (am_mag == 16'd0) ? 32'd0 :
                                  (den == 16'd0) ? 32'hFFFF_FFFF : quot};
    end
  end

  // Sequencer and executor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      running_q <= 1'b0;
      ticks_q   <= '0;
      left_q    <= '0;
      right_q   <= '0;
      done_q    <= '0;
      rej_q     <= 1'b0;
      kind_q    <= '0;
      speed_q   <= '0;
      amount_q  <= '0;
      lvl_q     <= '0;
      neg_q     <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            kind_q   <= kind_i;
            speed_q  <= speed_i;
            amount_q <= amount_i;
            neg_q    <= (kind_i == tmcs_pkg::KindTurn);
            state_q  <= req.start ? StLvl : StDisp;
            case (kind_i)
              tmcs_pkg::KindDrive, tmcs_pkg::KindTurn: begin
                done_q <= '0;
                rej_q  <= !req.start;
              end
              tmcs_pkg::KindSet: begin
                rej_q   <= 1'b0;
                left_q  <= (left_level_i < -tmcs_pkg::LevelMax) ?
                           -tmcs_pkg::LevelMax : left_level_i;
                right_q <= (right_level_i < -tmcs_pkg::LevelMax) ?
                           -tmcs_pkg::LevelMax : right_level_i;
                done_q  <= 4'(count_q) + {3'd0, running_q};
                count_q <= '0;
                head_q  <= '0;
                tail_q  <= '0;
                running_q <= 1'b0;
                ticks_q <= '0;
              end
              default: begin
                rej_q  <= 1'b0;
                done_q <= {3'd0, running_q && (ticks_q == 32'd1)};
                if (running_q) begin
                  ticks_q <= ticks_q - 32'd1;
                  if (ticks_q == 32'd1) begin
                    running_q <= 1'b0;
                    left_q  <= '0;
                    right_q <= '0;
                  end
                end
              end
            endcase
          end
        end
        StLvl: begin
          if (div_done) begin
            lvl_q   <= speed_q[15] ? 16'(-lvl_sat) : 16'(lvl_sat);
            state_q <= req.start ? StTck : StPush;
          end
        end
        StTck: begin
          if (div_done) state_q <= StPush;
        end
        StPush: begin
          tail_q  <= tail_q + tmcs_pkg::QIdxW'(1);
          count_q <= count_q + tmcs_pkg::QCntW'(1);
          state_q <= StDisp;
        end
        StDisp: begin
          // One queued command is popped per cycle while no command is running.
          if (!running_q && count_q != '0) begin
            head_q  <= head_q + tmcs_pkg::QIdxW'(1);
            count_q <= count_q - tmcs_pkg::QCntW'(1);
            left_q  <= head_c.left;
            right_q <= head_c.right;
            if (head_c.ticks != 32'd0) begin
              running_q <= 1'b1;
              ticks_q   <= head_c.ticks;
            end else begin
              done_q <= done_q + 4'd1;
            end
          end else begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_ready_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
